// ===== sv/pmul_pkg.sv =====
package pmul_pkg;

    // field widths of the channels
    localparam int CMD_W       = 2;
    localparam int POWER_W     = 5;
    localparam int COEF_W      = 16;
    localparam int DEGREE_W    = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_POWER_W = 6;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int ACC_W       = 37;

    // default highest power held in each coefficient store
    localparam int MAX_DEGREE_DEF = 31;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_B = 1'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

endpackage

// ===== sv/pmul_if.sv =====
interface pmul_in_if;
    import pmul_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic [POWER_W-1:0]        power;
    logic signed [COEF_W-1:0]  coefficient;

    modport source (output valid, cmd, power, coefficient, input ready);
    modport sink   (input valid, cmd, power, coefficient, output ready);
endinterface

interface pmul_out_if;
    import pmul_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OUT_POWER_W-1:0]    product_power;
    logic signed [ACC_W-1:0]   product_coef;
    logic                      last;

    modport source (output valid, product_power, product_coef, last, input ready);
    modport sink   (input valid, product_power, product_coef, last, output ready);
endinterface

interface pmul_cfg_if;
    import pmul_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [DEGREE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pmul_mac.sv =====
module pmul_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmul_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [pmul_pkg::COEF_W-1:0] i_a,
    input  logic signed [pmul_pkg::COEF_W-1:0] i_b,
    output logic signed [pmul_pkg::ACC_W-1:0]  o_acc,
    output logic                               o_busy
);
    import pmul_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = i_ctl.vld | r_prod_vld;

endmodule

// ===== sv/polynomial_multiplier_unit.sv =====
// Polynomial multiplier by direct convolution.
// Channels: i_in carries commands (load A coefficient, load B coefficient,
// start), i_cfg writes the two degree registers (index 0 degree A, index 1
// degree B), o_out returns one product coefficient per transfer.
// A load returns nothing; a load above the store
// depth is dropped. Start walks powers 0 to degree_a + degree_b and returns
// one coefficient per power, the highest one flagged with last.
// Each coefficient is built by one shared multiply-accumulate unit fed from
// the two coefficient stores, one term product per cycle: for each power the
// sequencer clears the accumulator, issues the terms, drains the unit and
// emits the sum to the output register.
// i_in is not ready while a run is in progress; one command at a time.
// If the receiver stalls, the current coefficient holds in the output
// register; the next is summed, then held until the current is taken.
// Reset clears the degree registers and control; the stores are not
// cleared and every coefficient used must be loaded first.
module polynomial_multiplier_unit #(
    parameter int MAX_DEGREE = pmul_pkg::MAX_DEGREE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmul_in_if.sink     i_in,
    pmul_cfg_if.sink    i_cfg,
    pmul_out_if.source  o_out
);
    import pmul_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = AW + 1;

    // coefficient stores
    logic signed [COEF_W-1:0] mem_a [DEPTH];
    logic signed [COEF_W-1:0] mem_b [DEPTH];

    t_state r_state, n_state;

    logic [DEGREE_W-1:0] r_degree_a, r_degree_b;
    logic [PW-1:0]       r_p;
    logic [AW-1:0]       r_i, r_hi;

    logic signed [COEF_W-1:0] r_rd_a, r_rd_b;
    logic                     r_rd_vld;

    logic                     r_out_valid;
    logic [OUT_POWER_W-1:0]   r_out_power;
    logic signed [ACC_W-1:0]  r_out_coef;
    logic                     r_out_last;

    logic [AW-1:0] da, db, lo, hi, j;
    logic [PW-1:0] top;
    logic          in_xfer, load_ok, out_free, mac_busy;
    logic          issue, emit;
    t_mac_ctl      mac_ctl;
    logic signed [ACC_W-1:0] mac_acc;

    // clamped degrees and term range of the current power
    assign da  = (r_degree_a > DEGREE_W'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : r_degree_a[AW-1:0];
    assign db  = (r_degree_b > DEGREE_W'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : r_degree_b[AW-1:0];
    assign top = PW'(da) + PW'(db);
    assign lo  = (r_p > PW'(db)) ? AW'(r_p - PW'(db)) : '0;
    assign hi  = (r_p < PW'(da)) ? r_p[AW-1:0] : da;
    assign j   = AW'(r_p - PW'(r_i));

    assign in_xfer  = i_in.valid & i_in.ready;
    assign load_ok  = (i_in.power <= POWER_W'(MAX_DEGREE));
    assign out_free = ~r_out_valid | o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in.cmd == CMD_START) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (r_i == r_hi) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_p == top) ? ST_IDLE : ST_NEXT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_in.ready  = 1'b0;
        issue       = 1'b0;
        emit        = 1'b0;
        mac_ctl.clr = 1'b0;
        case (r_state)
            ST_IDLE:  i_in.ready  = 1'b1;
            ST_NEXT:  mac_ctl.clr = 1'b1;
            ST_ISSUE: issue       = 1'b1;
            ST_EMIT:  emit        = out_free;
            default: begin
                issue = 1'b0;
            end
        endcase
        mac_ctl.vld = r_rd_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // degree registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree_a <= '0;
            r_degree_b <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEGREE_A: r_degree_a <= i_cfg.data;
                CFG_DEGREE_B: r_degree_b <= i_cfg.data;
                default: begin
                    r_degree_a <= r_degree_a;
                end
            endcase
        end
    end

    // coefficient store writes
    always_ff @(posedge i_clk) begin
        if (in_xfer && load_ok) begin
            case (i_in.cmd)
                CMD_LOAD_A: mem_a[i_in.power[AW-1:0]] <= i_in.coefficient;
                CMD_LOAD_B: mem_b[i_in.power[AW-1:0]] <= i_in.coefficient;
                default: begin
                end
            endcase
        end
    end

    // registered store reads, one term per cycle
    always_ff @(posedge i_clk) begin
        r_rd_a <= mem_a[r_i];
        r_rd_b <= mem_b[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    // power and term counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_i  <= '0;
            r_hi <= '0;
        end else begin
            if (r_state == ST_IDLE) begin
                r_p <= '0;
            end else if (emit && r_p != top) begin
                r_p <= r_p + PW'(1);
            end
            if (r_state == ST_NEXT) begin
                r_i  <= lo;
                r_hi <= hi;
            end else if (issue && r_i != r_hi) begin
                r_i <= r_i + AW'(1);
            end
        end
    end

    pmul_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_power <= OUT_POWER_W'(r_p);
            r_out_coef  <= mac_acc;
            r_out_last  <= (r_p == top);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.product_power = r_out_power;
    assign o_out.product_coef  = r_out_coef;
    assign o_out.last          = r_out_last;

    // checks on the sequencer
    a_power_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE || r_state == ST_DRAIN || r_state == ST_EMIT) |-> r_p <= top)
        else $error("power counter beyond top power");

    a_term_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_i <= r_hi && r_i <= da && j <= db))
        else $error("term index outside the convolution range");

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (!mac_busy && !r_rd_vld))
        else $error("coefficient emitted before accumulation finished");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.cmd == CMD_START) |=> !i_in.ready)
        else $error("input taken during a run");

endmodule

// ===== tb/polynomial_multiplier_unit_tb.sv =====
`timescale 1ns / 100ps

module polynomial_multiplier_unit_tb;
    import pmul_pkg::*;

    localparam int MAX_DEG       = MAX_DEGREE_DEF;
    localparam int RANDOM_ITEMS  = 260;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 20;

    // command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POWER_W-1:0]       power;
        logic signed [COEF_W-1:0] coef;
    } t_poly_cmd;

    typedef struct packed {
        logic [OUT_POWER_W-1:0]  power;
        logic signed [ACC_W-1:0] coef;
        logic                    last;
    } t_poly_term;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pmul_in_if  in_if ();
    pmul_cfg_if cfg_if ();
    pmul_out_if out_if ();

    // driven copies, known from time zero
    logic                     in_valid  = 1'b0;
    logic [CMD_W-1:0]         in_cmd    = CMD_LOAD_A;
    logic [POWER_W-1:0]       in_power  = '0;
    logic signed [COEF_W-1:0] in_coef   = '0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_DEGREE_A;
    logic [DEGREE_W-1:0]      cfg_data  = '0;
    logic                     out_ready = 1'b0;

    assign in_if.valid       = in_valid;
    assign in_if.cmd         = in_cmd;
    assign in_if.power       = in_power;
    assign in_if.coefficient = in_coef;
    assign cfg_if.valid      = cfg_valid;
    assign cfg_if.index      = cfg_index;
    assign cfg_if.data       = cfg_data;
    assign out_if.ready      = out_ready;

    logic in_xfer, cfg_xfer, out_xfer;
    assign in_xfer  = in_if.valid && in_if.ready;
    assign cfg_xfer = cfg_if.valid && cfg_if.ready;
    assign out_xfer = out_if.valid && out_if.ready;

    polynomial_multiplier_unit DUT (
        .i_clk,
        .i_rst_n,
        .i_in  (in_if),
        .i_cfg (cfg_if),
        .o_out (out_if)
    );

    t_poly_cmd   cmd_queue[$];
    t_poly_term  expected_terms[$];
    bit          burst_mode    = 1'b0;
    int unsigned in_gap        = 0;
    int unsigned out_stall     = 0;
    int unsigned out_draw;
    int unsigned idle_cycles   = 0;
    int          errors        = 0;
    int          items_sent    = 0;
    int          multiplies    = 0;
    int          terms_checked = 0;

    // predictor state
    logic signed [COEF_W-1:0] store_a [MAX_DEG+1];
    logic signed [COEF_W-1:0] store_b [MAX_DEG+1];
    logic [DEGREE_W-1:0]      deg_a_reg = '0;
    logic [DEGREE_W-1:0]      deg_b_reg = '0;

    // stimulus bookkeeping: which entries have been written so far
    bit a_loaded [MAX_DEG+1];
    bit b_loaded [MAX_DEG+1];
    int gen_deg_a = 0;
    int gen_deg_b = 0;
    int issued    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // predictor: store writes on loads, convolution of the two stores on start
    task automatic apply_command(input t_poly_cmd item);
        int         top;
        int         lim_a;
        int         lim_b;
        longint     acc;
        t_poly_term term;
        items_sent++;
        case (item.cmd)
            CMD_LOAD_A: begin
                if (item.power <= MAX_DEG) store_a[item.power] = item.coef;
            end
            CMD_LOAD_B: begin
                if (item.power <= MAX_DEG) store_b[item.power] = item.coef;
            end
            CMD_START: begin
                multiplies++;
                lim_a = (deg_a_reg > MAX_DEG) ? MAX_DEG : int'(deg_a_reg);
                lim_b = (deg_b_reg > MAX_DEG) ? MAX_DEG : int'(deg_b_reg);
                top   = lim_a + lim_b;
                for (int p = 0; p <= top; p++) begin
                    acc = 0;
                    for (int i = 0; i <= lim_a; i++) begin
                        if (i <= p && p - i <= lim_b) begin
                            acc += longint'(store_a[i]) * longint'(store_b[p - i]);
                        end
                    end
                    term.power = OUT_POWER_W'(p);
                    term.coef  = ACC_W'(acc);
                    term.last  = (p == top);
                    expected_terms.push_back(term);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_term();
        t_poly_term want;
        if (expected_terms.size() == 0) begin
            report_mismatch($sformatf("unexpected product term at power %0d",
                                      out_if.product_power));
        end else begin
            want = expected_terms.pop_front();
            terms_checked++;
            if (out_if.product_power !== want.power)
                report_mismatch($sformatf("product_power %0d, want %0d",
                                          out_if.product_power, want.power));
            if (out_if.product_coef !== want.coef)
                report_mismatch($sformatf("power %0d product_coef %0d, want %0d",
                                          want.power, out_if.product_coef, want.coef));
            if (out_if.last !== want.last)
                report_mismatch($sformatf("power %0d last %0b, want %0b",
                                          want.power, out_if.last, want.last));
        end
    endtask

    // command driver: one queued item at a time, random gap after each transfer outside burst mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else if (!in_valid || in_if.ready) begin
            if (in_gap != 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                {in_cmd, in_power, in_coef} <= cmd_queue.pop_front();
                in_valid <= 1'b1;
                in_gap   <= burst_mode ? 0 : $urandom_range(0, 9);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall after each transfer outside burst mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else if (out_xfer) begin
            out_draw = burst_mode ? 0 : $urandom_range(0, 9);
            out_stall <= out_draw;
            out_ready <= (out_draw == 0);
        end else if (out_stall != 0) begin
            out_stall <= out_stall - 1;
            out_ready <= (out_stall == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: track register writes, predict on commands, check results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            deg_a_reg <= '0;
            deg_b_reg <= '0;
        end else begin
            if (cfg_xfer) begin
                case (cfg_index)
                    CFG_DEGREE_A: deg_a_reg <= cfg_data;
                    CFG_DEGREE_B: deg_b_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer) apply_command({in_cmd, in_power, in_coef});
            if (out_xfer) check_term();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || in_xfer || cfg_xfer || out_xfer) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d terms outstanding",
                     STALL_LIMIT, expected_terms.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'shFFFF;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic int pick_degree();
        return ($urandom_range(0, 9) == 0) ? MAX_DEG : int'($urandom_range(0, 6));
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [POWER_W-1:0] power,
                              input logic signed [COEF_W-1:0] coef);
        cmd_queue.push_back('{cmd, power, coef});
        issued++;
    endtask

    task automatic queue_load(input bit sel_b, input logic [POWER_W-1:0] power,
                              input logic signed [COEF_W-1:0] coef);
        queue_item(sel_b ? CMD_LOAD_B : CMD_LOAD_A, power, coef);
        if (sel_b) b_loaded[power] = 1'b1;
        else       a_loaded[power] = 1'b1;
    endtask

    // every coefficient the multiply reads must have been loaded first
    task automatic queue_multiply();
        for (int p = 0; p <= gen_deg_a; p++) begin
            if (!a_loaded[p]) queue_load(1'b0, POWER_W'(p), random_coef());
        end
        for (int p = 0; p <= gen_deg_b; p++) begin
            if (!b_loaded[p]) queue_load(1'b1, POWER_W'(p), random_coef());
        end
        queue_item(CMD_START, POWER_W'($urandom), COEF_W'($urandom));
    endtask

    // hold off until every command is sent and every term has come back
    task automatic wait_idle(input int cycles);
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || in_valid || expected_terms.size() != 0);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DEGREE_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_degrees(input int da, input int db);
        write_cfg(CFG_DEGREE_A, DEGREE_W'(da));
        write_cfg(CFG_DEGREE_B, DEGREE_W'(db));
        gen_deg_a = da;
        gen_deg_b = db;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        bit sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-term products at the coefficient extremes, unused command, silent load
        set_degrees(0, 0);
        queue_load(1'b0, 5'd0, 16'sh8000);
        queue_load(1'b1, 5'd0, 16'sh8000);
        queue_item(CMD_START, '0, '0);
        queue_item(CMD_UNUSED, 5'd31, 16'shFFFF);
        queue_load(1'b0, 5'd0, 16'sh7FFF);
        queue_item(CMD_START, 5'd31, 16'sh7FFF);
        wait_idle(SETTLE_CYCLES);

        // short mixed-sign polynomials
        set_degrees(3, 2);
        queue_load(1'b0, 5'd0, 16'sd1);
        queue_load(1'b0, 5'd1, -16'sd1);
        queue_load(1'b0, 5'd2, 16'sh7FFF);
        queue_load(1'b0, 5'd3, 16'sh8000);
        queue_load(1'b1, 5'd0, 16'sh7FFF);
        queue_load(1'b1, 5'd1, 16'sh8000);
        queue_load(1'b1, 5'd2, 16'sd1);
        queue_load(1'b0, 5'd31, 16'sh5555);
        queue_multiply();
        wait_idle(SETTLE_CYCLES);

        // constant times a longer polynomial
        set_degrees(0, 4);
        queue_load(1'b1, 5'd3, -16'sd2);
        queue_load(1'b1, 5'd4, 16'sh2AAA);
        queue_multiply();
        wait_idle(SETTLE_CYCLES);

        // full degree with every term at its extreme: largest then smallest sums
        set_degrees(MAX_DEG, MAX_DEG);
        for (int p = 0; p <= MAX_DEG; p++) begin
            queue_load(1'b0, POWER_W'(p), 16'sh8000);
            queue_load(1'b1, POWER_W'(p), 16'sh8000);
        end
        queue_multiply();
        for (int p = 0; p <= MAX_DEG; p++) queue_load(1'b1, POWER_W'(p), 16'sh7FFF);
        queue_multiply();
        wait_idle(SETTLE_CYCLES);

        // random phases: new degrees, then load-and-multiply sequences with some noise
        while (issued < RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            set_degrees(pick_degree(), pick_degree());
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 5)) begin
                    sel = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 7) == 0)
                        queue_item(CMD_UNUSED, POWER_W'($urandom), COEF_W'($urandom));
                    else if ($urandom_range(0, 2) == 0)
                        queue_load(sel, POWER_W'($urandom_range(0, MAX_DEG)), random_coef());
                    else
                        queue_load(sel,
                                   POWER_W'($urandom_range(0, sel ? gen_deg_b : gen_deg_a)),
                                   random_coef());
                end
                queue_multiply();
            end
            wait_idle(SETTLE_CYCLES);
        end
        burst_mode = 1'b0;
        wait_idle(TAIL_CYCLES);

        if (expected_terms.size() != 0)
            report_mismatch($sformatf("%0d product terms never arrived",
                                      expected_terms.size()));

        $display("run covered %0d commands and %0d multiplies, %0d product terms checked",
                 items_sent, multiplies, terms_checked);
        $display("degrees 0 to %0d, coefficient extremes, unused commands, random stalls",
                 MAX_DEG);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pmul_pkg.sv
sv/pmul_if.sv
sv/pmul_mac.sv
sv/polynomial_multiplier_unit.sv
tb/polynomial_multiplier_unit_tb.sv
